>>> rtl/ppl_pkg.sv
// ----------------------------------------------------------------------------
// ppl_pkg
// shared types and codes for the positional pair list
// ----------------------------------------------------------------------------
package ppl_pkg;

  localparam int unsigned DefDepth       = 16;
  localparam int unsigned DefFirstWidth  = 32;
  localparam int unsigned DefSecondWidth = 32;

  localparam int unsigned PosWidth   = 5;
  localparam int unsigned ValWidth   = 32;
  localparam int unsigned CountWidth = 5;

  typedef enum logic [1:0] {
    CmdAppend = 2'd0,
    CmdInsert = 2'd1,
    CmdRemove = 2'd2,
    CmdRead   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  // per-cell move control, at most one bit set
  typedef struct packed {
    logic load_new;    // take the incoming word
    logic from_left;   // take the lower neighbor (shift up)
    logic from_right;  // take the upper neighbor (shift down)
  } cell_ctrl_t;

endpackage

>>> rtl/ppl_cell.sv
// ----------------------------------------------------------------------------
// ppl_cell
// one list slot: holds a pair and loads from input or either neighbor
// ----------------------------------------------------------------------------
module ppl_cell
  import ppl_pkg::*;
#(
  parameter int unsigned FirstWidth  = DefFirstWidth,
  parameter int unsigned SecondWidth = DefSecondWidth
) (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [FirstWidth-1:0]  new_first_i,
  input  logic [SecondWidth-1:0] new_second_i,
  input  logic [FirstWidth-1:0]  left_first_i,
  input  logic [SecondWidth-1:0] left_second_i,
  input  logic [FirstWidth-1:0]  right_first_i,
  input  logic [SecondWidth-1:0] right_second_i,
  output logic [FirstWidth-1:0]  first_o,
  output logic [SecondWidth-1:0] second_o
);

  logic [FirstWidth-1:0]  first_q, first_d;
  logic [SecondWidth-1:0] second_q, second_d;

  always_comb begin
    priority if (ctrl_i.load_new) begin
      first_d  = new_first_i;
      second_d = new_second_i;
    end else if (ctrl_i.from_left) begin
      first_d  = left_first_i;
      second_d = left_second_i;
    end else if (ctrl_i.from_right) begin
      first_d  = right_first_i;
      second_d = right_second_i;
    end else begin
      first_d  = first_q;
      second_d = second_q;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

  assign first_o  = first_q;
  assign second_o = second_q;

endmodule

>>> rtl/positional_pair_list_core.sv
// ----------------------------------------------------------------------------
// positional_pair_list_core
// bounded ordered list of value pairs with append, insert, remove and read
// ----------------------------------------------------------------------------
// result: the result word is registered and shows on the cycle after start is taken
// throughput: one command word per cycle, all cells shift in parallel
// busy stays low, the receiver cannot stall so nothing backs up
// reset clears the entry count and the result strobe; cell contents are
// undefined until written and are never read before that
module positional_pair_list_core
  import ppl_pkg::*;
#(
  parameter int unsigned Depth       = DefDepth,
  parameter int unsigned FirstWidth  = DefFirstWidth,
  parameter int unsigned SecondWidth = DefSecondWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command_i,
  input  logic [PosWidth-1:0]   position_i,
  input  logic [ValWidth-1:0]   first_value_i,
  input  logic [ValWidth-1:0]   second_value_i,
  output logic                  valid_o,
  output logic [1:0]            status_o,
  output logic [ValWidth-1:0]   pair_first_o,
  output logic [ValWidth-1:0]   pair_second_o,
  output logic [CountWidth-1:0] count_o
);

  // count holds 0..Depth, compares run at the wider of count and position
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > PosWidth) ? CntW : PosWidth;
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  // one command every cycle, nothing to wait for
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // entry count
  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] cnt_x, pos_x;

  assign cnt_x = CmpW'(count_q);
  assign pos_x = CmpW'(position_i);

  cmd_e cmd;
  assign cmd = cmd_e'(command_i);

  logic full;
  assign full = (cnt_x == CmpW'(Depth));

  // incoming pair trimmed or widened to the stored width
  logic [FirstWidth-1:0]  new_first;
  logic [SecondWidth-1:0] new_second;

  always_comb begin
    new_first  = '0;
    new_second = '0;
    for (int b = 0; b < FirstWidth; b++) begin
      if (b < ValWidth) new_first[b] = first_value_i[b];
    end
    for (int b = 0; b < SecondWidth; b++) begin
      if (b < ValWidth) new_second[b] = second_value_i[b];
    end
  end

  // decode the command into what the chain does this cycle
  logic    do_append, do_insert, do_remove;
  status_e status_d;
  logic    want_pair;

  always_comb begin
    do_append = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    want_pair = 1'b0;
    status_d  = StOk;
    count_d   = count_q;
    unique case (cmd)
      CmdAppend: begin
        if (full) begin
          status_d = StFull;
        end else begin
          do_append = 1'b1;
          count_d   = count_q + CntW'(1);
        end
      end
      CmdInsert: begin
        // fullness wins over a bad position
        if (full) begin
          status_d = StFull;
        end else if (pos_x > cnt_x) begin
          status_d = StRange;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + CntW'(1);
        end
      end
      CmdRemove: begin
        if (pos_x >= cnt_x) begin
          status_d = StRange;
        end else begin
          do_remove = 1'b1;
          want_pair = 1'b1;
          count_d   = count_q - CntW'(1);
        end
      end
      CmdRead: begin
        if (pos_x >= cnt_x) begin
          status_d = StRange;
        end else begin
          want_pair = 1'b1;
        end
      end
      default: status_d = StOk;
    endcase
  end

  // the chain of cells
  logic [FirstWidth-1:0]  cell_first  [Depth];
  logic [SecondWidth-1:0] cell_second [Depth];
  cell_ctrl_t             cell_ctrl   [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    localparam logic [CmpW-1:0] Here = CmpW'(i);

    logic [FirstWidth-1:0]  left_first,  right_first;
    logic [SecondWidth-1:0] left_second, right_second;

    // edge cells see themselves where no neighbor exists
    if (i == 0) begin : g_lo
      assign left_first  = cell_first[i];
      assign left_second = cell_second[i];
    end else begin : g_lo_n
      assign left_first  = cell_first[i-1];
      assign left_second = cell_second[i-1];
    end
    if (i == Depth - 1) begin : g_hi
      assign right_first  = cell_first[i];
      assign right_second = cell_second[i];
    end else begin : g_hi_n
      assign right_first  = cell_first[i+1];
      assign right_second = cell_second[i+1];
    end

    // cells past the end may shift freely, their contents do not matter
    always_comb begin
      cell_ctrl[i].load_new   = accept & ((do_append & (Here == cnt_x)) |
                                          (do_insert & (Here == pos_x)));
      cell_ctrl[i].from_left  = accept & do_insert & (Here > pos_x);
      cell_ctrl[i].from_right = accept & do_remove & (Here >= pos_x);
    end

    ppl_cell #(
      .FirstWidth  (FirstWidth),
      .SecondWidth (SecondWidth)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (cell_ctrl[i]),
      .new_first_i    (new_first),
      .new_second_i   (new_second),
      .left_first_i   (left_first),
      .left_second_i  (left_second),
      .right_first_i  (right_first),
      .right_second_i (right_second),
      .first_o        (cell_first[i]),
      .second_o       (cell_second[i])
    );
  end

  // pick the addressed pair, only used when the position is in range
  logic [IdxW-1:0]        rd_idx;
  logic [FirstWidth-1:0]  rd_first;
  logic [SecondWidth-1:0] rd_second;
  logic [ValWidth-1:0]    pair_first_d, pair_second_d;

  assign rd_idx    = pos_x[IdxW-1:0];
  assign rd_first  = cell_first[rd_idx];
  assign rd_second = cell_second[rd_idx];

  always_comb begin
    pair_first_d  = '0;
    pair_second_d = '0;
    if (want_pair) begin
      for (int b = 0; b < ValWidth; b++) begin
        if (b < FirstWidth)  pair_first_d[b]  = rd_first[b];
        if (b < SecondWidth) pair_second_d[b] = rd_second[b];
      end
    end
  end

  // count and strobe are control state, result payload is not reset
  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) count_q <= count_d;
    end
  end

  logic [1:0]            status_q;
  logic [ValWidth-1:0]   pair_first_q, pair_second_q;
  logic [CountWidth-1:0] count_out_q;
  logic [CmpW-1:0]       count_d_x;

  assign count_d_x = CmpW'(count_d);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      pair_first_q  <= pair_first_d;
      pair_second_q <= pair_second_d;
      count_out_q   <= count_d_x[CountWidth-1:0];
    end
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign pair_first_o  = pair_first_q;
  assign pair_second_o = pair_second_q;
  assign count_o       = count_out_q;

endmodule
